### src/btlpm_pkg.sv
// Shared types, constants and helpers of the binary trie prefix match unit.
package btlpm_pkg;

    localparam int MAX_NODES  = 4096;
    localparam int MAX_ROUTES = 1024;
    localparam int ADDR_BITS  = 32;
    localparam int ROUTE_W    = 10;
    localparam int NODE_AW    = $clog2(MAX_NODES);
    localparam int CNT_W      = $clog2(MAX_NODES + 1);
    localparam int LEVEL_W    = $clog2(ADDR_BITS + 1);
    localparam int NODE_W     = 1 + ROUTE_W + 2 * NODE_AW;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_LOOKUP = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_MATCH = 2'd1,
        STATUS_FULL     = 2'd2
    } status_t;

    typedef enum logic {
        W_IDLE,
        W_WALK
    } walk_state_t;

    typedef struct packed {
        req_type_t                req_type;
        logic [ADDR_BITS-1:0]     route_prefix;
        logic [ADDR_BITS-1:0]     route_mask;
        logic [ROUTE_W-1:0]       route_id;
        logic [ADDR_BITS-1:0]     lookup_address;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic                     route_found;
        logic [ROUTE_W-1:0]       matched_route;
    } rsp_t;

    typedef struct packed {
        logic                     has_route;
        logic [ROUTE_W-1:0]       route;
        logic [NODE_AW-1:0]       child0;
        logic [NODE_AW-1:0]       child1;
    } node_t;

    typedef struct packed {
        logic                     rd_en;
        logic [NODE_AW-1:0]       rd_addr;
        logic                     wr_en;
        logic [NODE_AW-1:0]       wr_addr;
        logic [NODE_W-1:0]        wr_data;
    } ram_req_t;

    typedef struct packed {
        logic                     valid;
        rsp_t                     rsp;
    } res_t;

    // A route number is installed only when it fits the route table.
    function automatic logic route_ok(input logic [ROUTE_W-1:0] id);
        return int'(id) < MAX_ROUTES;
    endfunction

endpackage

### src/btlpm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module btlpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/btlpm_walker.sv
// Trie walk sequencer: insert and lookup, one trie level per cycle.
module btlpm_walker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  btlpm_pkg::req_t               s_data,
    input  logic                          out_free,
    output btlpm_pkg::res_t               res,
    output btlpm_pkg::ram_req_t           ram,
    input  logic [btlpm_pkg::NODE_W-1:0]  rd_data
);

    btlpm_pkg::walk_state_t              state_reg, state_next;
    logic [btlpm_pkg::NODE_AW-1:0]       cur_reg, cur_next;
    btlpm_pkg::node_t                    node_reg, node_next;
    logic                                from_ram_reg, from_ram_next;
    logic [btlpm_pkg::LEVEL_W-1:0]       level_reg, level_next;
    logic [btlpm_pkg::ADDR_BITS-1:0]     key_reg, key_next;
    logic [btlpm_pkg::ADDR_BITS-1:0]     mask_reg, mask_next;
    logic                                lookup_reg, lookup_next;
    logic [btlpm_pkg::ROUTE_W-1:0]       rid_reg, rid_next;
    logic                                id_ok_reg, id_ok_next;
    logic                                found_reg, found_next;
    logic [btlpm_pkg::ROUTE_W-1:0]       best_reg, best_next;
    logic [btlpm_pkg::CNT_W-1:0]         used_reg, used_next;
    logic                                root_init_reg, root_init_next;

    btlpm_pkg::node_t                    node;
    btlpm_pkg::node_t                    node_upd;
    logic [btlpm_pkg::NODE_AW-1:0]       child;
    logic [btlpm_pkg::NODE_AW-1:0]       new_idx;
    logic                                hit;
    logic [btlpm_pkg::ROUTE_W-1:0]       best_sel;

    // A node that was just allocated is never fetched; it is known to be empty.
    assign node    = from_ram_reg ? btlpm_pkg::node_t'(rd_data) : node_reg;
    assign child   = key_reg[btlpm_pkg::ADDR_BITS-1] ? node.child1 : node.child0;
    assign new_idx = used_reg[btlpm_pkg::NODE_AW-1:0];
    assign hit      = found_reg | node.has_route;
    assign best_sel = node.has_route ? node.route : best_reg;
    assign s_ready  = (state_reg == btlpm_pkg::W_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= btlpm_pkg::W_IDLE;
            used_reg      <= btlpm_pkg::CNT_W'(1);
            root_init_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            root_init_reg <= root_init_next;
        end
        cur_reg      <= cur_next;
        node_reg     <= node_next;
        from_ram_reg <= from_ram_next;
        level_reg    <= level_next;
        key_reg      <= key_next;
        mask_reg     <= mask_next;
        lookup_reg   <= lookup_next;
        rid_reg      <= rid_next;
        id_ok_reg    <= id_ok_next;
        found_reg    <= found_next;
        best_reg     <= best_next;
    end

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        node_next      = node_reg;
        from_ram_next  = from_ram_reg;
        level_next     = level_reg;
        key_next       = key_reg;
        mask_next      = mask_reg;
        lookup_next    = lookup_reg;
        rid_next       = rid_reg;
        id_ok_next     = id_ok_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        used_next      = used_reg;
        root_init_next = root_init_reg;
        ram            = '0;
        res            = '0;
        node_upd       = node;

        case (state_reg)
            btlpm_pkg::W_IDLE: begin
                if (s_valid) begin
                    lookup_next = (s_data.req_type == btlpm_pkg::REQ_LOOKUP);
                    key_next    = lookup_next ? s_data.lookup_address : s_data.route_prefix;
                    mask_next   = s_data.route_mask;
                    rid_next    = s_data.route_id;
                    id_ok_next  = btlpm_pkg::route_ok(s_data.route_id);
                    cur_next    = '0;
                    level_next  = '0;
                    found_next  = 1'b0;
                    best_next   = '0;
                    node_next   = '0;
                    if (root_init_reg) begin
                        ram.rd_en     = 1'b1;
                        ram.rd_addr   = '0;
                        from_ram_next = 1'b1;
                    end else begin
                        from_ram_next = 1'b0;
                    end
                    state_next = btlpm_pkg::W_WALK;
                end
            end
            btlpm_pkg::W_WALK: begin
                if (lookup_reg) begin
                    if (level_reg == btlpm_pkg::LEVEL_W'(btlpm_pkg::ADDR_BITS) || child == '0) begin
                        if (out_free) begin
                            res.valid             = 1'b1;
                            res.rsp.status        = hit ? btlpm_pkg::STATUS_OK
                                                        : btlpm_pkg::STATUS_NO_MATCH;
                            res.rsp.route_found   = hit;
                            res.rsp.matched_route = hit ? best_sel : '0;
                            state_next            = btlpm_pkg::W_IDLE;
                        end
                    end else begin
                        found_next    = hit;
                        best_next     = best_sel;
                        cur_next      = child;
                        ram.rd_en     = 1'b1;
                        ram.rd_addr   = child;
                        from_ram_next = 1'b1;
                        level_next    = level_reg + 1'b1;
                        key_next      = key_reg << 1;
                    end
                end else if (!id_ok_reg) begin
                    if (out_free) begin
                        res.valid      = 1'b1;
                        res.rsp.status = btlpm_pkg::STATUS_OK;
                        state_next     = btlpm_pkg::W_IDLE;
                    end
                end else if (mask_reg == '0) begin
                    // Prefix consumed: install the route here, overwriting any older one.
                    if (out_free) begin
                        node_upd.has_route = 1'b1;
                        node_upd.route     = rid_reg;
                        ram.wr_en          = 1'b1;
                        ram.wr_addr        = cur_reg;
                        ram.wr_data        = node_upd;
                        res.valid          = 1'b1;
                        res.rsp.status     = btlpm_pkg::STATUS_OK;
                        state_next         = btlpm_pkg::W_IDLE;
                    end
                end else if (child != '0) begin
                    cur_next      = child;
                    ram.rd_en     = 1'b1;
                    ram.rd_addr   = child;
                    from_ram_next = 1'b1;
                    key_next      = key_reg << 1;
                    mask_next     = mask_reg << 1;
                end else if (used_reg == btlpm_pkg::CNT_W'(btlpm_pkg::MAX_NODES)) begin
                    // Store full. The current node may be freshly allocated and still
                    // unwritten, so it is written out so that its parent link stays sound.
                    if (out_free) begin
                        ram.wr_en      = 1'b1;
                        ram.wr_addr    = cur_reg;
                        ram.wr_data    = node;
                        res.valid      = 1'b1;
                        res.rsp.status = btlpm_pkg::STATUS_FULL;
                        state_next     = btlpm_pkg::W_IDLE;
                    end
                end else begin
                    if (key_reg[btlpm_pkg::ADDR_BITS-1]) begin
                        node_upd.child1 = new_idx;
                    end else begin
                        node_upd.child0 = new_idx;
                    end
                    ram.wr_en     = 1'b1;
                    ram.wr_addr   = cur_reg;
                    ram.wr_data   = node_upd;
                    cur_next      = new_idx;
                    node_next     = '0;
                    from_ram_next = 1'b0;
                    used_next     = used_reg + 1'b1;
                    key_next      = key_reg << 1;
                    mask_next     = mask_reg << 1;
                end
            end
            default: begin
                state_next = btlpm_pkg::W_IDLE;
            end
        endcase

        if (ram.wr_en && ram.wr_addr == '0) begin
            root_init_next = 1'b1;
        end
    end

endmodule

### src/binary_trie_longest_prefix_match_unit.sv
// Top level of the binary trie longest prefix match unit.
// An item is accepted and then walked down the trie level by level into its result
// register; one item is in the walk at a time.
// The walk is bound by the single node memory access per level (registered read port).
// Reset (synchronous, active low) empties the trie at once: no clearing pass is run.
// The result register lets the next item be accepted while a result waits.
module binary_trie_longest_prefix_match_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  btlpm_pkg::req_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output btlpm_pkg::rsp_t   m_data
);

    // The trie lives in one node memory. Each entry carries a route valid bit, a
    // route number and the two child indices; index zero is the root, and a child
    // index of zero means there is no child. Entries are only read after they have
    // been allocated and written, which the node count guarantees. The root alone is
    // read before any write, so a flag in the walker makes it read as empty until
    // its first write.
    btlpm_pkg::ram_req_t              ram;
    logic [btlpm_pkg::NODE_W-1:0]     rd_data;
    btlpm_pkg::res_t                  res;
    logic                             out_free;

    logic                             m_valid_reg, m_valid_next;
    btlpm_pkg::rsp_t                  m_data_reg, m_data_next;

    btlpm_ram #(
        .WIDTH (btlpm_pkg::NODE_W),
        .DEPTH (btlpm_pkg::MAX_NODES)
    ) u_node_ram (
        .aclk    (aclk),
        .wr_en   (ram.wr_en),
        .wr_addr (ram.wr_addr),
        .wr_data (ram.wr_data),
        .rd_en   (ram.rd_en),
        .rd_addr (ram.rd_addr),
        .rd_data (rd_data)
    );

    // The walker finishes an item only when the result register can take it;
    // otherwise it holds its last level until the downstream side drains.
    btlpm_walker u_walker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .out_free (out_free),
        .res      (res),
        .ram      (ram),
        .rd_data  (rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res.valid) begin
            m_valid_next = 1'b1;
            m_data_next  = res.rsp;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A finished item must never overwrite a result that is still waiting.
    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while an item was pending");

    // Only one item is in the walk at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted during a walk");

    // A level either follows an existing link (read) or writes a node (to allocate or install), never both.
    a_read_or_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram.rd_en && ram.wr_en))
        else $error("node memory read and written in the same cycle");

    // A found route always comes with an OK status.
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.route_found) |-> (m_data.status == btlpm_pkg::STATUS_OK))
        else $error("route found with a non-OK status");

endmodule

### dv/tb_binary_trie_longest_prefix_match_unit.sv
// Self-checking testbench of the binary trie longest prefix match unit.
module tb_binary_trie_longest_prefix_match_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import btlpm_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 12;
    // Settle time that covers the longest walk to the result register.
    localparam int SETTLE_CYCLES    = 40;
    // Longest correct stretch without a handshake is the receiver hold plus one walk.
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int POOL_SIZE        = 8;
    localparam int WARMUP_ITEMS     = 550;
    localparam int HOLD_AT_ITEM     = 200;
    localparam int FULL_ITEMS       = 40;
    localparam int CLOSING_ITEMS    = 250;
    localparam int QUIET_TAIL       = 100;

    // The scoreboard keeps its own copy of the trie. Every accepted item is
    // applied to that copy in acceptance order, and the answer it should give
    // is queued. Answers leave the block in order, so each one is compared
    // with the oldest entry of the queue.
    class lpm_scoreboard;
        logic [NODE_AW-1:0] child0    [MAX_NODES];
        logic [NODE_AW-1:0] child1    [MAX_NODES];
        logic [ROUTE_W-1:0] route_at  [MAX_NODES];
        bit                 has_route [MAX_NODES];
        int                 nodes_used;
        rsp_t               expected_answers [$];
        int                 mismatches;

        function new();
            foreach (child0[i]) begin
                child0[i]    = '0;
                child1[i]    = '0;
                route_at[i]  = '0;
                has_route[i] = 1'b0;
            end
            nodes_used = 1;
            mismatches = 0;
        endfunction

        // Walks the prefix while mask bits remain, growing missing nodes. When
        // the node store runs dry the walk stops and the route is dropped;
        // nodes grown so far stay in place without a route.
        function status_t install_route(logic [ADDR_BITS-1:0] prefix,
                                        logic [ADDR_BITS-1:0] mask,
                                        logic [ROUTE_W-1:0] id);
            int cur;
            int nxt;
            int lvl;
            cur = 0;
            for (lvl = 0; lvl < ADDR_BITS; lvl++) begin
                if (mask == '0) break;
                nxt = prefix[ADDR_BITS-1] ? int'(child1[cur]) : int'(child0[cur]);
                if (nxt == 0) begin
                    if (nodes_used >= MAX_NODES) return STATUS_FULL;
                    nxt = nodes_used;
                    child0[nxt]    = '0;
                    child1[nxt]    = '0;
                    route_at[nxt]  = '0;
                    has_route[nxt] = 1'b0;
                    if (prefix[ADDR_BITS-1]) child1[cur] = NODE_AW'(nxt);
                    else child0[cur] = NODE_AW'(nxt);
                    nodes_used++;
                end
                cur    = nxt;
                prefix = prefix << 1;
                mask   = mask << 1;
            end
            route_at[cur]  = id;
            has_route[cur] = 1'b1;
            return STATUS_OK;
        endfunction

        // Follows the address down the trie and keeps the deepest route seen.
        // A route on the root is a default and counts as a match.
        function rsp_t match_address(logic [ADDR_BITS-1:0] addr);
            rsp_t               ans;
            int                 cur;
            int                 nxt;
            int                 lvl;
            bit                 hit;
            logic [ROUTE_W-1:0] best;
            cur  = 0;
            hit  = has_route[0];
            best = hit ? route_at[0] : '0;
            for (lvl = 0; lvl < ADDR_BITS; lvl++) begin
                nxt = addr[ADDR_BITS-1] ? int'(child1[cur]) : int'(child0[cur]);
                if (nxt == 0) break;
                cur = nxt;
                if (has_route[cur]) begin
                    hit  = 1'b1;
                    best = route_at[cur];
                end
                addr = addr << 1;
            end
            ans               = '0;
            ans.status        = hit ? STATUS_OK : STATUS_NO_MATCH;
            ans.route_found   = hit;
            ans.matched_route = hit ? best : '0;
            return ans;
        endfunction

        function void note_request(req_t r);
            rsp_t want;
            want = '0;
            if (r.req_type == REQ_INSERT) begin
                // A route number beyond the route table is dropped silently.
                want.status = STATUS_OK;
                if (int'(r.route_id) < MAX_ROUTES)
                    want.status = install_route(r.route_prefix, r.route_mask, r.route_id);
            end else begin
                want = match_address(r.lookup_address);
            end
            expected_answers.push_back(want);
        endfunction

        function void check_answer(rsp_t got);
            rsp_t want;
            if (expected_answers.size() == 0) begin
                $error("unexpected answer: status %0d route_found %0d matched_route %0d",
                       got.status, got.route_found, got.matched_route);
                mismatches++;
                return;
            end
            want = expected_answers.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.route_found !== want.route_found) begin
                $error("route_found: expected %0d, got %0d", want.route_found, got.route_found);
                mismatches++;
            end
            if (got.matched_route !== want.matched_route) begin
                $error("matched_route: expected %0d, got %0d",
                       want.matched_route, got.matched_route);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_answers.size();
        endfunction
    endclass

    // All block inputs hold known values from time zero.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    // Controls of the receiving side. Both are written with nonblocking
    // assignments so that the receiver sees a stable value at every edge.
    bit hold_answers   = 1'b0;
    bit sink_stalls_on = 1'b1;

    logic [ADDR_BITS-1:0] base_pool [POOL_SIZE];

    lpm_scoreboard sb = new();

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    binary_trie_longest_prefix_match_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A mask with the given number of leading ones.
    function automatic logic [ADDR_BITS-1:0] prefix_mask(input int len);
        if (len == 0) return '0;
        return {ADDR_BITS{1'b1}} << (ADDR_BITS - len);
    endfunction

    // Fields that an insert ignores are filled with random bits, and the
    // same is done for the fields that a lookup ignores.
    function automatic req_t insert_req(input logic [ADDR_BITS-1:0] prefix,
                                        input logic [ADDR_BITS-1:0] mask,
                                        input logic [ROUTE_W-1:0] id);
        req_t r;
        r.req_type       = REQ_INSERT;
        r.route_prefix   = prefix;
        r.route_mask     = mask;
        r.route_id       = id;
        r.lookup_address = $urandom;
        return r;
    endfunction

    function automatic req_t lookup_req(input logic [ADDR_BITS-1:0] addr);
        req_t r;
        r.req_type       = REQ_LOOKUP;
        r.route_prefix   = $urandom;
        r.route_mask     = $urandom;
        r.route_id       = ROUTE_W'($urandom);
        r.lookup_address = addr;
        return r;
    endfunction

    // Most random items stay close to a handful of base prefixes, so that
    // inserts share trie paths and lookups land on installed routes. The low
    // bits get a random scramble to branch off at any depth, from depth four down for inserts.
    function automatic req_t random_request();
        logic [ADDR_BITS-1:0] base;
        logic [ADDR_BITS-1:0] mask;
        int                   len;
        base = base_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 99) < 40) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(25, ADDR_BITS)
                                              : $urandom_range(0, 24);
            // Some masks are raw noise; the walk then runs down to the lowest set bit.
            mask = ($urandom_range(0, 99) < 15) ? $urandom : prefix_mask(len);
            return insert_req(base ^ ($urandom >> $urandom_range(4, ADDR_BITS)), mask,
                              ROUTE_W'($urandom));
        end
        if ($urandom_range(0, 4) == 0) return lookup_req($urandom);
        return lookup_req(base ^ ($urandom >> $urandom_range(0, ADDR_BITS)));
    endfunction

    // Offers one item and returns at the edge where it is accepted. An idle
    // gap lowers valid first; without one, valid simply stays high and only
    // the payload moves on to the next item.
    task automatic offer_request(input req_t r, input bit may_idle);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
    endtask

    // Stops offering and waits until every answer has come back. At least
    // one edge passes, so valid is never lowered and raised in one step.
    task automatic wait_for_all_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
    endtask

    // Receiver: checks each accepted answer and then decides whether it takes
    // the next one. Short stalls come at random, and on request it holds off
    // for a long stretch so that the result register and the walk both fill
    // and the block stops taking items.
    initial begin : answer_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_answer(m_data);
            if (stall_left > 0) begin
                stall_left--;
            end else if (hold_answers) begin
                stall_left = SINK_HOLD_CYCLES;
                hold_answers <= 1'b0;
            end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 3);
            end
            m_ready <= (stall_left == 0);
        end
    end

    // Watchdog: a hung block shows up as a long run of cycles without any
    // handshake on either side.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        req_t r;
        int   i;

        foreach (base_pool[k]) base_pool[k] = $urandom;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Lookups into the empty trie find nothing at either
        // end of the address range.
        offer_request(lookup_req('0), 1'b1);
        offer_request(lookup_req('1), 1'b1);
        // A zero mask puts the default route on the root, which then matches
        // any address.
        offer_request(insert_req(32'h1234_5678, '0, 10'd1023), 1'b1);
        offer_request(lookup_req(32'h5A5A_A5A5), 1'b1);
        // A one-bit prefix and the two host routes at the ends of the range.
        offer_request(insert_req(32'h8000_0000, 32'h8000_0000, 10'd0), 1'b1);
        offer_request(insert_req('1, '1, 10'd5), 1'b1);
        offer_request(insert_req('0, '1, 10'd1), 1'b1);
        offer_request(lookup_req('1), 1'b1);
        offer_request(lookup_req(32'hFFFF_FFFE), 1'b1);
        offer_request(lookup_req('0), 1'b1);
        offer_request(lookup_req(32'h7FFF_FFFF), 1'b1);
        // A mask with holes: only its lowest set bit decides the depth.
        offer_request(insert_req(32'h0A00_0000, 32'h0000_0100, 10'd77), 1'b1);
        offer_request(lookup_req(32'h0A00_00FF), 1'b1);
        offer_request(lookup_req(32'h0A00_01FF), 1'b1);
        // A second insert at the same node replaces the first route.
        offer_request(insert_req('1, '1, 10'd6), 1'b1);
        offer_request(lookup_req('1), 1'b1);
        // Ignored fields all ones on both kinds of item.
        r = insert_req(32'hC0A8_0000, prefix_mask(16), 10'd512);
        r.lookup_address = '1;
        offer_request(r, 1'b1);
        r = lookup_req(32'hC0A8_0101);
        r.route_prefix = '1;
        r.route_mask   = '1;
        r.route_id     = '1;
        offer_request(r, 1'b1);
        // The default route can be replaced as well.
        offer_request(insert_req('0, '0, 10'd0), 1'b0);
        offer_request(lookup_req(32'h7000_0000), 1'b0);

        // Random part, with one long receiver hold partway through while the
        // items keep coming.
        for (i = 0; i < WARMUP_ITEMS; i++) begin
            if (i == HOLD_AT_ITEM) hold_answers <= 1'b1;
            offer_request(random_request(), 1'b1);
        end

        // Let the block run completely dry before the next phase.
        wait_for_all_results();

        // Exhaust the node store with host routes at random addresses, then
        // keep inserting so that new paths meet a full store.
        while (sb.nodes_used < MAX_NODES) begin
            if ($urandom_range(0, 3) == 0) r = random_request();
            else r = insert_req($urandom, prefix_mask(ADDR_BITS), ROUTE_W'($urandom));
            offer_request(r, 1'b1);
        end
        repeat (FULL_ITEMS) begin
            offer_request(insert_req($urandom, prefix_mask(ADDR_BITS), ROUTE_W'($urandom)),
                          1'b1);
        end

        // With the store full, inserts on existing paths still overwrite
        // routes. The closing stretch ends with a tail run without idling on either side.
        for (i = 0; i < CLOSING_ITEMS; i++) begin
            if (i == CLOSING_ITEMS - QUIET_TAIL) sink_stalls_on <= 1'b0;
            offer_request(random_request(), i < CLOSING_ITEMS - QUIET_TAIL);
        end

        wait_for_all_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### sim.f
src/btlpm_pkg.sv
src/btlpm_ram.sv
src/btlpm_walker.sv
src/binary_trie_longest_prefix_match_unit.sv
dv/tb_binary_trie_longest_prefix_match_unit.sv
